// ===== src/f2h_pkg.sv =====
package f2h_pkg;

  typedef struct packed {
    logic [31:0] fp32_bits;
    logic        last_in;
  } f2h_in_t;

  typedef struct packed {
    logic [15:0] fp16_bits;
    logic        last_out;
  } f2h_out_t;

  localparam logic [30:0] F32_INF_BITS  = 31'h7f800000;
  localparam logic [30:0] F32_OVF_BITS  = 31'h47800000;
  localparam logic [14:0] F16_INF_BITS  = 15'h7c00;
  localparam logic [14:0] F16_QUIET_BIT = 15'h0200;
  localparam logic [7:0]  EXP_NORM_MIN  = 8'd113;
  localparam logic [7:0]  EXP_SUB_BASE  = 8'd126;

endpackage

// ===== src/f2h_core.sv =====
module f2h_core
  import f2h_pkg::*;
(
  input  logic [31:0] x,
  output logic [15:0] h
);

  logic [30:0] a;
  logic [7:0]  e;
  logic [22:0] mant;
  logic [14:0] nq;
  logic        nrnd;
  logic [23:0] sig;
  logic [7:0]  sh;
  logic [4:0]  shc;
  logic [47:0] ext;
  logic [23:0] q;
  logic [23:0] rem;
  logic [23:0] half;
  logic        srnd;
  logic [14:0] sq;
  logic [14:0] mag;

  always_comb begin
    a    = x[30:0];
    e    = a[30:23];
    mant = a[22:0];
    nq   = {(e[4:0] - 5'd16), mant[22:13]};
    nrnd = mant[12] && ((mant[11:0] != 12'd0) || nq[0]);
    sig  = {1'b1, mant};
    sh   = EXP_SUB_BASE - e;
    shc  = (sh > 8'd24) ? 5'd24 : sh[4:0];
    ext  = {sig, 24'd0} >> shc;
    q    = ext[47:24];
    rem  = ext[23:0];
    half = 24'h800000;
    srnd = (rem > half) || ((rem == half) && q[0]);
    sq   = q[14:0] + {14'd0, srnd};
    if (a > F32_INF_BITS) begin
      mag = F16_INF_BITS | F16_QUIET_BIT | {5'd0, a[22:13]};
    end else if (a >= F32_OVF_BITS) begin
      mag = F16_INF_BITS;
    end else if (e == 8'd0) begin
      mag = 15'd0;
    end else if (e >= EXP_NORM_MIN) begin
      mag = nq + {14'd0, nrnd};
    end else if (sh > 8'd24) begin
      mag = 15'd0;
    end else begin
      mag = sq;
    end
    h = {x[31], mag};
  end

endmodule

// ===== src/fp32_to_fp16_convert_top.sv =====
// binary32 to binary16 converter, round to nearest even
// path from start to strobe: input register, then result register
// throughput: one word per cycle; busy is always low
// the receiver cannot stall; each result shows for one cycle with strobe
// synchronous active-high reset clears the valid flags only
module fp32_to_fp16_convert_top
  import f2h_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  f2h_in_t  in_word,
  output logic     strobe,
  output f2h_out_t out_word
);

  f2h_in_t     in_reg;
  logic        in_vld;
  logic [15:0] h;

  assign busy = 1'b0;

  f2h_core u_core (
    .x (in_reg.fp32_bits),
    .h (h)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      in_vld <= start;
      strobe <= in_vld;
    end
    if (start) in_reg <= in_word;
    out_word.fp16_bits <= h;
    out_word.last_out  <= in_reg.last_in;
  end

endmodule

// ===== src/f2h_check.sv =====
module f2h_check
  import f2h_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input f2h_in_t  in_word,
  input logic     strobe,
  input f2h_out_t out_word
);

  a_strobe_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 strobe) else $error("missing result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 2)) else $error("spurious result");

  a_last: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 (out_word.last_out == $past(in_word.last_in, 2)))
    else $error("last flag mismatch");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 (out_word.fp16_bits[15] == $past(in_word.fp32_bits[31], 2)))
    else $error("sign mismatch");

endmodule

bind fp32_to_fp16_convert_top f2h_check u_f2h_check (.*);

// ===== tb/testbench.sv =====
module testbench;
  import f2h_pkg::*;

  class half_scoreboard;
    f2h_out_t pending[$];
    int errors;

    function logic [15:0] round_even(logic [31:0] sig, int unsigned sh);
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] half;
      if (sh == 0) return sig[15:0];
      if (sh > 24) return 16'h0;
      q = sig >> sh;
      rem = sig & ((32'h1 << sh) - 1);
      half = 32'h1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      return q[15:0];
    endfunction

    function logic [15:0] to_half(logic [31:0] x);
      logic [15:0] sgn;
      logic [30:0] mag;
      logic [7:0] ex;
      logic [22:0] man;
      logic [31:0] h;
      sgn = {x[31], 15'h0};
      mag = x[30:0];
      ex = mag[30:23];
      man = mag[22:0];
      if (mag > F32_INF_BITS) return sgn | {1'b0, F16_INF_BITS | F16_QUIET_BIT | mag[22:13]};
      if (mag >= F32_OVF_BITS) return sgn | {1'b0, F16_INF_BITS};
      if (ex == 0) return sgn;
      if (ex >= EXP_NORM_MIN) begin
        h = ({24'h0, ex - EXP_NORM_MIN + 8'd1} << 23) | {9'h0, man};
        h = {16'h0, round_even(h, 13)};
        return sgn | {1'b0, h[14:0]};
      end
      h = {16'h0, round_even({8'h0, 1'b1, man}, EXP_SUB_BASE - ex)};
      return sgn | {1'b0, h[14:0]};
    endfunction

    function void note_word(f2h_in_t w);
      f2h_out_t e;
      e.fp16_bits = to_half(w.fp32_bits);
      e.last_out = w.last_in;
      pending.push_back(e);
    endfunction

    function void check_word(f2h_out_t got);
      f2h_out_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.fp16_bits !== e.fp16_bits) begin
        $display("%0t fp16_bits expected %h actual %h", $time, e.fp16_bits, got.fp16_bits);
        errors++;
      end
      if (got.last_out !== e.last_out) begin
        $display("%0t last_out expected %b actual %b", $time, e.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic strobe;
  f2h_in_t in_word;
  f2h_out_t out_word;
  half_scoreboard sb;
  int cycles;
  bit quiet;

  fp32_to_fp16_convert_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .strobe(strobe), .out_word(out_word)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_word(out_word);
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] bits, logic lst);
    f2h_in_t w;
    w.fp32_bits = bits;
    w.last_in = lst;
    while (!quiet && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    logic [7:0] ex;
    v = $urandom();
    case ($urandom_range(5))
      0: ex = 8'($urandom_range(100, 142));
      1: ex = 8'($urandom_range(110, 115));
      2: ex = 8'($urandom_range(140, 143));
      3: ex = $urandom_range(1) ? 8'hff : 8'h00;
      default: ex = 8'($urandom_range(255));
    endcase
    v[30:23] = ex;
    if ($urandom_range(7) == 0) v[12:0] = $urandom_range(1) ? 13'h1000 : 13'h0;
    return v;
  endfunction

  initial begin
    logic [31:0] directed[$];
    sb = new();
    cycles = 0;
    quiet = 0;
    rst = 1;
    start = 0;
    in_word = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    directed = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h807fffff,
                 32'h7f800000, 32'hff800000, 32'h7fc00000, 32'h7f800001,
                 32'hffffffff, 32'h7fa02000, 32'h477fe000, 32'h477fefff,
                 32'h477ff000, 32'hc77ff000, 32'h47800000, 32'h7f7fffff,
                 32'h38800000, 32'h387fe000, 32'h387ff000, 32'h33800000,
                 32'h33000000, 32'h33000001, 32'h3f801000, 32'h3f803000,
                 32'h3f800fff};
    foreach (directed[i]) send_word(directed[i], i[0]);
    for (int i = 0; i < 750; i++) begin
      quiet = (i >= 300 && i < 400);
      if (i == 500) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_word(rand_float(), 1'($urandom_range(1)));
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
